// File: design/assert_macros.svh
// assertion macros used by the top level of this block
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/psm_pkg.sv
// types, codes and helper functions of the ps/2 mouse device
// no dependencies
package psm_pkg;

    // item kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_MOVE  = 2'd2;

    // reply bytes
    localparam logic [7:0] BYTE_ACK    = 8'hFA;
    localparam logic [7:0] BYTE_NAK    = 8'hFE;
    localparam logic [7:0] BYTE_BAT_OK = 8'hAA;
    localparam logic [7:0] BYTE_DEV_ID = 8'h00;

    // host commands
    localparam logic [7:0] CMD_RESET        = 8'hFF;
    localparam logic [7:0] CMD_RESEND       = 8'hFE;
    localparam logic [7:0] CMD_SET_DEFAULTS = 8'hF6;
    localparam logic [7:0] CMD_DISABLE      = 8'hF5;
    localparam logic [7:0] CMD_ENABLE       = 8'hF4;
    localparam logic [7:0] CMD_SET_RATE     = 8'hF3;
    localparam logic [7:0] CMD_GET_ID       = 8'hF2;
    localparam logic [7:0] CMD_SET_REMOTE   = 8'hF0;
    localparam logic [7:0] CMD_SET_WRAP     = 8'hEE;
    localparam logic [7:0] CMD_RESET_WRAP   = 8'hEC;
    localparam logic [7:0] CMD_READ_DATA    = 8'hEB;
    localparam logic [7:0] CMD_SET_STREAM   = 8'hEA;
    localparam logic [7:0] CMD_STATUS       = 8'hE9;
    localparam logic [7:0] CMD_SET_RES      = 8'hE8;
    localparam logic [7:0] CMD_SCALE_2      = 8'hE7;
    localparam logic [7:0] CMD_SCALE_1      = 8'hE6;

    localparam logic [7:0] RES_DEFAULT  = 8'd2;
    localparam logic [7:0] RATE_DEFAULT = 8'd100;

    // queue depths between the parts
    localparam int JOBQ_DEPTH = 4;
    localparam int RESQ_DEPTH = 2;

    typedef enum logic [1:0] {
        PS_CMD  = 2'd0,
        PS_RATE = 2'd1,
        PS_WRAP = 2'd2,
        PS_RES  = 2'd3
    } psm_proto_t;

    typedef enum logic {
        JOB_WRITE = 1'b0,
        JOB_READ  = 1'b1
    } psm_op_t;

    typedef enum logic [2:0] {
        BK_INIT_BAT,
        BK_INIT_ID,
        BK_IDLE,
        BK_PUSH,
        BK_READ
    } psm_back_state_t;

    // work handed from the front part to the back part
    typedef struct packed {
        psm_op_t         op;
        logic [2:0]      nbytes;
        logic [3:0][7:0] data;
        logic            irq;
        logic            write_ok;
    } psm_job_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic [7:0] bytes_left;
        logic       irq;
        logic       write_ok;
    } psm_result_t;

    typedef struct packed {
        logic signed [8:0] value;
        logic              over;
    } psm_acc_t;

    // add the shifted delta; out of range folds to the truncated remainder by 255
    function automatic psm_acc_t accumulate(logic signed [8:0] cnt,
                                            logic signed [10:0] delta,
                                            logic [7:0] res);
        logic [1:0]         sh;
        logic signed [14:0] wide_cnt;
        logic signed [14:0] wide_delta;
        logic signed [14:0] sum;
        logic [14:0]        neg_sum;
        logic [13:0]        mag;
        logic [13:0]        quot;
        logic [13:0]        rem;
        logic [13:0]        neg_rem;
        psm_acc_t           acc;
        sh         = (res > 8'd3) ? 2'd3 : res[1:0];
        wide_cnt   = $signed({{6{cnt[8]}}, cnt});
        wide_delta = $signed({{4{delta[10]}}, delta});
        sum        = wide_cnt + (wide_delta <<< sh);
        neg_sum    = 15'(-sum);
        mag        = sum[14] ? neg_sum[13:0] : sum[13:0];
        // divide by 255 with the x + x/256 + 1 reciprocal
        quot       = (mag + (mag >> 8) + 14'd1) >> 8;
        rem        = mag - (quot << 8) + quot;
        neg_rem    = 14'(-rem);
        acc.over   = (sum > 15'sd255) || (sum < -15'sd256);
        if (acc.over)
            acc.value = sum[14] ? $signed(neg_rem[8:0]) : $signed(rem[8:0]);
        else
            acc.value = sum[8:0];
        return acc;
    endfunction

    // 2:1 scaling of one packet byte
    function automatic logic [7:0] scale_byte(logic [7:0] n, logic dbl);
        logic [7:0] s;
        if (!dbl) begin
            s = n;
        end
        else begin
            case (n)
                8'd0, 8'd1, 8'd3: s = n;
                8'd2:             s = 8'd1;
                8'd4:             s = 8'd6;
                8'd5:             s = 8'd9;
                default:          s = {n[6:0], 1'b0};
            endcase
        end
        return s;
    endfunction

    // first byte of a movement packet; buttons bit0 left, bit1 middle, bit2 right
    function automatic logic [7:0] packet_head(logic [2:0] btn, logic x_neg, logic y_neg,
                                               logic x_ovf, logic y_ovf);
        return {y_ovf, x_ovf, y_neg, x_neg, 1'b1, btn[1], btn[2], btn[0]};
    endfunction

endpackage

// File: design/psm_ram.sv
// generic single write port ram with registered read
// no dependencies
module psm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: design/psm_queue.sv
// small first-in first-out queue in flip-flops
// no dependencies
module psm_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

// File: design/psm_front.sv
// front part: protocol state, settings and movement counters; turns each item into a job
// depends on psm_pkg
module psm_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [1:0]             kind,
    input  logic [7:0]             cmd_byte,
    input  logic signed [10:0]     move_x,
    input  logic signed [10:0]     move_y,
    input  logic                   btn_left,
    input  logic                   btn_middle,
    input  logic                   btn_right,
    input  logic                   buttons_present,
    output psm_pkg::psm_job_t      job
);

    logic signed [8:0]   x_count_reg, x_count_next;
    logic signed [8:0]   y_count_reg, y_count_next;
    logic                x_over_reg, x_over_next;
    logic                y_over_reg, y_over_next;
    logic [2:0]          buttons_reg, buttons_next;
    logic                double_scale_reg, double_scale_next;
    logic                remote_mode_reg, remote_mode_next;
    psm_pkg::psm_proto_t proto_state_reg, proto_state_next;
    logic [7:0]          resolution_reg, resolution_next;
    logic [7:0]          sample_rate_reg, sample_rate_next;
    logic                reporting_on_reg, reporting_on_next;

    psm_pkg::psm_acc_t   acc_x, acc_y;
    logic [2:0]          new_buttons;
    logic [2:0]          event_buttons;
    logic                moved;
    logic                x_ovf_new, y_ovf_new;

    assign acc_x = psm_pkg::accumulate(x_count_reg, move_x, resolution_reg);
    assign acc_y = psm_pkg::accumulate(y_count_reg, move_y, resolution_reg);
    assign new_buttons   = {btn_right, btn_middle, btn_left};
    assign event_buttons = buttons_present ? new_buttons : buttons_reg;
    assign moved = !(move_x == 11'sd0 && move_y == 11'sd0
                     && (!buttons_present || new_buttons == buttons_reg));
    assign x_ovf_new = x_over_reg | acc_x.over;
    assign y_ovf_new = y_over_reg | acc_y.over;

    always_comb
    begin
        x_count_next      = x_count_reg;
        y_count_next      = y_count_reg;
        x_over_next       = x_over_reg;
        y_over_next       = y_over_reg;
        buttons_next      = buttons_reg;
        double_scale_next = double_scale_reg;
        remote_mode_next  = remote_mode_reg;
        proto_state_next  = proto_state_reg;
        resolution_next   = resolution_reg;
        sample_rate_next  = sample_rate_reg;
        reporting_on_next = reporting_on_reg;
        job               = '0;
        job.op            = psm_pkg::JOB_WRITE;

        if (accept)
        begin
            case (kind)
                psm_pkg::KIND_WRITE:
                begin
                    job.irq = 1'b1;
                    if (proto_state_reg == psm_pkg::PS_RATE)
                    begin
                        sample_rate_next = cmd_byte;
                        proto_state_next = psm_pkg::PS_CMD;
                        job.nbytes  = 3'd1;
                        job.data[0] = psm_pkg::BYTE_ACK;
                    end
                    else if (proto_state_reg == psm_pkg::PS_RES)
                    begin
                        resolution_next  = cmd_byte;
                        proto_state_next = psm_pkg::PS_CMD;
                        job.nbytes  = 3'd1;
                        job.data[0] = psm_pkg::BYTE_ACK;
                    end
                    else if (proto_state_reg == psm_pkg::PS_WRAP
                             && cmd_byte != psm_pkg::CMD_RESET_WRAP
                             && cmd_byte != psm_pkg::CMD_RESET)
                    begin
                        // wrap mode echoes the byte
                        job.nbytes  = 3'd1;
                        job.data[0] = cmd_byte;
                    end
                    else
                    begin
                        job.write_ok = 1'b1;
                        job.nbytes   = 3'd1;
                        job.data[0]  = psm_pkg::BYTE_ACK;
                        case (cmd_byte)
                            psm_pkg::CMD_RESET:
                            begin
                                double_scale_next = 1'b0;
                                remote_mode_next  = 1'b0;
                                proto_state_next  = psm_pkg::PS_CMD;
                                reporting_on_next = 1'b0;
                                resolution_next   = psm_pkg::RES_DEFAULT;
                                sample_rate_next  = psm_pkg::RATE_DEFAULT;
                                job.nbytes  = 3'd3;
                                job.data[1] = psm_pkg::BYTE_BAT_OK;
                                job.data[2] = psm_pkg::BYTE_DEV_ID;
                            end
                            psm_pkg::CMD_RESEND:
                            begin
                                job.write_ok = 1'b0;
                                job.nbytes   = 3'd0;
                            end
                            psm_pkg::CMD_SET_DEFAULTS:
                            begin
                                double_scale_next = 1'b0;
                                remote_mode_next  = 1'b0;
                                proto_state_next  = psm_pkg::PS_CMD;
                                reporting_on_next = 1'b0;
                                resolution_next   = psm_pkg::RES_DEFAULT;
                                sample_rate_next  = psm_pkg::RATE_DEFAULT;
                            end
                            psm_pkg::CMD_DISABLE:
                                reporting_on_next = 1'b0;
                            psm_pkg::CMD_ENABLE:
                                reporting_on_next = 1'b1;
                            psm_pkg::CMD_SET_RATE:
                                proto_state_next = psm_pkg::PS_RATE;
                            psm_pkg::CMD_GET_ID:
                            begin
                                job.nbytes  = 3'd3;
                                job.data[1] = psm_pkg::BYTE_DEV_ID;
                                job.data[2] = psm_pkg::BYTE_DEV_ID;
                            end
                            psm_pkg::CMD_SET_REMOTE:
                            begin
                                x_count_next     = '0;
                                y_count_next     = '0;
                                x_over_next      = 1'b0;
                                y_over_next      = 1'b0;
                                remote_mode_next = 1'b1;
                            end
                            psm_pkg::CMD_SET_WRAP:
                            begin
                                x_count_next     = '0;
                                y_count_next     = '0;
                                x_over_next      = 1'b0;
                                y_over_next      = 1'b0;
                                proto_state_next = psm_pkg::PS_WRAP;
                            end
                            psm_pkg::CMD_RESET_WRAP:
                            begin
                                x_count_next     = '0;
                                y_count_next     = '0;
                                x_over_next      = 1'b0;
                                y_over_next      = 1'b0;
                                proto_state_next = psm_pkg::PS_CMD;
                            end
                            psm_pkg::CMD_READ_DATA:
                            begin
                                job.nbytes  = 3'd4;
                                job.data[1] = psm_pkg::packet_head(buttons_reg,
                                    x_count_reg[8], y_count_reg[8], x_over_reg, y_over_reg);
                                job.data[2] = psm_pkg::scale_byte(x_count_reg[7:0],
                                    double_scale_reg);
                                job.data[3] = psm_pkg::scale_byte(y_count_reg[7:0],
                                    double_scale_reg);
                                x_count_next = '0;
                                y_count_next = '0;
                                x_over_next  = 1'b0;
                                y_over_next  = 1'b0;
                            end
                            psm_pkg::CMD_SET_STREAM:
                            begin
                                x_count_next     = '0;
                                y_count_next     = '0;
                                x_over_next      = 1'b0;
                                y_over_next      = 1'b0;
                                remote_mode_next = 1'b0;
                            end
                            psm_pkg::CMD_STATUS:
                            begin
                                job.nbytes  = 3'd4;
                                job.data[1] = {1'b0, remote_mode_reg, reporting_on_reg,
                                               double_scale_reg, 1'b0, buttons_reg[0],
                                               buttons_reg[1], buttons_reg[2]};
                                job.data[2] = resolution_reg;
                                job.data[3] = sample_rate_reg;
                            end
                            psm_pkg::CMD_SET_RES:
                                proto_state_next = psm_pkg::PS_RES;
                            psm_pkg::CMD_SCALE_2:
                                double_scale_next = 1'b1;
                            psm_pkg::CMD_SCALE_1:
                                double_scale_next = 1'b0;
                            default:
                                job.data[0] = psm_pkg::BYTE_NAK;
                        endcase
                    end
                end
                psm_pkg::KIND_READ:
                    job.op = psm_pkg::JOB_READ;
                psm_pkg::KIND_MOVE:
                begin
                    if (moved)
                    begin
                        buttons_next = event_buttons;
                        x_count_next = acc_x.value;
                        y_count_next = acc_y.value;
                        x_over_next  = x_ovf_new;
                        y_over_next  = y_ovf_new;
                        if (!remote_mode_reg && reporting_on_reg)
                        begin
                            job.irq     = 1'b1;
                            job.nbytes  = 3'd3;
                            job.data[0] = psm_pkg::packet_head(event_buttons,
                                acc_x.value[8], acc_y.value[8], x_ovf_new, y_ovf_new);
                            job.data[1] = psm_pkg::scale_byte(acc_x.value[7:0],
                                double_scale_reg);
                            job.data[2] = psm_pkg::scale_byte(acc_y.value[7:0],
                                double_scale_reg);
                            x_count_next = '0;
                            y_count_next = '0;
                            x_over_next  = 1'b0;
                            y_over_next  = 1'b0;
                        end
                    end
                end
                default:
                begin
                    // undefined kind: no state change, all-zero result
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_count_reg      <= '0;
            y_count_reg      <= '0;
            x_over_reg       <= 1'b0;
            y_over_reg       <= 1'b0;
            buttons_reg      <= '0;
            double_scale_reg <= 1'b0;
            remote_mode_reg  <= 1'b0;
            proto_state_reg  <= psm_pkg::PS_CMD;
            resolution_reg   <= psm_pkg::RES_DEFAULT;
            sample_rate_reg  <= psm_pkg::RATE_DEFAULT;
            reporting_on_reg <= 1'b0;
        end
        else
        begin
            x_count_reg      <= x_count_next;
            y_count_reg      <= y_count_next;
            x_over_reg       <= x_over_next;
            y_over_reg       <= y_over_next;
            buttons_reg      <= buttons_next;
            double_scale_reg <= double_scale_next;
            remote_mode_reg  <= remote_mode_next;
            proto_state_reg  <= proto_state_next;
            resolution_reg   <= resolution_next;
            sample_rate_reg  <= sample_rate_next;
            reporting_on_reg <= reporting_on_next;
        end
    end

endmodule

// File: design/psm_back.sv
// back part: owns the reply fifo, pushes reply bytes one a cycle and serves host reads
// depends on psm_pkg and psm_ram
module psm_back #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_valid,
    input  psm_pkg::psm_job_t    job,
    output logic                 job_take,
    input  logic                 res_full,
    output logic                 res_push,
    output psm_pkg::psm_result_t res
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam int FW = (CW > 8) ? CW : 8;

    psm_pkg::psm_back_state_t state_reg, state_next;
    psm_pkg::psm_job_t        job_reg, job_next;
    logic [1:0]               idx_reg, idx_next;
    logic [AW-1:0]            head_reg, head_next;
    logic [AW-1:0]            tail_reg, tail_next;
    logic [CW-1:0]            fill_reg, fill_next;

    logic                     push_en;
    logic [7:0]               push_byte;
    logic                     push_ok;
    logic                     rd_en;
    logic [7:0]               rd_data;
    logic [FW-1:0]            fill_wide;

    assign fill_wide = FW'(fill_reg);
    assign push_ok   = push_en && (fill_reg != CW'(FIFO_DEPTH));

    psm_ram #(
        .WIDTH (8),
        .DEPTH (FIFO_DEPTH)
    ) u_reply_ram (
        .clk     (clk),
        .wr_en   (push_ok),
        .wr_addr (tail_reg),
        .wr_data (push_byte),
        .rd_en   (rd_en),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        idx_next   = idx_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        fill_next  = fill_reg;
        push_en    = 1'b0;
        push_byte  = job_reg.data[idx_reg];
        rd_en      = 1'b0;
        job_take   = 1'b0;
        res_push   = 1'b0;
        res        = '0;

        case (state_reg)
            psm_pkg::BK_INIT_BAT:
            begin
                // power-on reply bytes
                push_en    = 1'b1;
                push_byte  = psm_pkg::BYTE_BAT_OK;
                state_next = psm_pkg::BK_INIT_ID;
            end
            psm_pkg::BK_INIT_ID:
            begin
                push_en    = 1'b1;
                push_byte  = psm_pkg::BYTE_DEV_ID;
                state_next = psm_pkg::BK_IDLE;
            end
            psm_pkg::BK_IDLE:
            begin
                // one job in flight, so a free result slot now is still free at the end
                if (job_valid && !res_full)
                begin
                    job_take = 1'b1;
                    if (job.op == psm_pkg::JOB_READ)
                    begin
                        if (fill_reg != '0)
                        begin
                            rd_en      = 1'b1;
                            head_next  = (head_reg == AW'(FIFO_DEPTH - 1)) ? '0
                                                                           : head_reg + 1'b1;
                            fill_next  = fill_reg - 1'b1;
                            state_next = psm_pkg::BK_READ;
                        end
                        else
                        begin
                            res_push = 1'b1;
                        end
                    end
                    else if (job.nbytes == 3'd0)
                    begin
                        res_push     = 1'b1;
                        res.irq      = job.irq;
                        res.write_ok = job.write_ok;
                    end
                    else
                    begin
                        job_next   = job;
                        idx_next   = '0;
                        state_next = psm_pkg::BK_PUSH;
                    end
                end
            end
            psm_pkg::BK_PUSH:
            begin
                push_en = 1'b1;
                if ({1'b0, idx_reg} + 3'd1 == job_reg.nbytes)
                begin
                    res_push     = 1'b1;
                    res.irq      = job_reg.irq;
                    res.write_ok = job_reg.write_ok;
                    state_next   = psm_pkg::BK_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            psm_pkg::BK_READ:
            begin
                res_push       = 1'b1;
                res.read_byte  = rd_data;
                res.bytes_left = (fill_wide > FW'(255)) ? 8'hFF : fill_wide[7:0];
                state_next     = psm_pkg::BK_IDLE;
            end
            default:
                state_next = psm_pkg::BK_IDLE;
        endcase

        // a byte pushed into a full fifo is dropped
        if (push_ok)
        begin
            tail_next = (tail_reg == AW'(FIFO_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psm_pkg::BK_INIT_BAT;
            idx_reg   <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end

endmodule

// File: design/ps2_mouse_device_unit.sv
// top level of the ps/2 mouse device: front part, job queue, back part, result queue
// depends on psm_pkg, psm_front, psm_queue, psm_back and assert_macros.svh
//
//   channel   handshake          payload
//   -------   ----------------   ---------------------------------------------------
//   input     push / full        kind, cmd_byte, move_x, move_y, btn_left,
//                                btn_middle, btn_right, buttons_present
//   result    empty / pop        read_byte, bytes_left, irq, write_ok
//
// an item is taken whenever the four-entry job queue has room; the back part then writes
// the reply bytes of a job, up to four for a command, one after another into the reply ram
// through its write port; for a host read it first reads the ram, then pushes the result.
// after reset the back part writes the two power-on bytes into the reply ram in its init
// states; items are accepted meanwhile and wait in the job queue.
// a stalled result side fills the two-entry result queue, then the job queue, then full.
`include "assert_macros.svh"

module ps2_mouse_device_unit #(
    parameter int FIFO_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         kind,
    input  logic [7:0]         cmd_byte,
    input  logic signed [10:0] move_x,
    input  logic signed [10:0] move_y,
    input  logic               btn_left,
    input  logic               btn_middle,
    input  logic               btn_right,
    input  logic               buttons_present,
    output logic               empty,
    input  logic               pop,
    output logic [7:0]         read_byte,
    output logic [7:0]         bytes_left,
    output logic               irq,
    output logic               write_ok
);

    localparam int JOB_W = $bits(psm_pkg::psm_job_t);
    localparam int RES_W = $bits(psm_pkg::psm_result_t);

    logic                 accept;
    psm_pkg::psm_job_t    front_job;
    logic                 jobq_full;
    logic                 jobq_empty;
    logic [JOB_W-1:0]     jobq_rd_data;
    psm_pkg::psm_job_t    job_head;
    logic                 job_take;
    logic                 resq_full;
    logic                 res_push;
    psm_pkg::psm_result_t back_res;
    logic [RES_W-1:0]     resq_rd_data;
    psm_pkg::psm_result_t res_head;

    assign full   = jobq_full;
    assign accept = push && !jobq_full;

    psm_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (accept),
        .kind            (kind),
        .cmd_byte        (cmd_byte),
        .move_x          (move_x),
        .move_y          (move_y),
        .btn_left        (btn_left),
        .btn_middle      (btn_middle),
        .btn_right       (btn_right),
        .buttons_present (buttons_present),
        .job             (front_job)
    );

    psm_queue #(
        .WIDTH (JOB_W),
        .DEPTH (psm_pkg::JOBQ_DEPTH)
    ) u_job_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (front_job),
        .full    (jobq_full),
        .rd_en   (job_take),
        .rd_data (jobq_rd_data),
        .empty   (jobq_empty)
    );

    assign job_head = psm_pkg::psm_job_t'(jobq_rd_data);

    psm_back #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (!jobq_empty),
        .job       (job_head),
        .job_take  (job_take),
        .res_full  (resq_full),
        .res_push  (res_push),
        .res       (back_res)
    );

    psm_queue #(
        .WIDTH (RES_W),
        .DEPTH (psm_pkg::RESQ_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (back_res),
        .full    (resq_full),
        .rd_en   (pop),
        .rd_data (resq_rd_data),
        .empty   (empty)
    );

    assign res_head   = psm_pkg::psm_result_t'(resq_rd_data);
    assign read_byte  = res_head.read_byte;
    assign bytes_left = res_head.bytes_left;
    assign irq        = res_head.irq;
    assign write_ok   = res_head.write_ok;

    `ASSERT_IMPLIES(a_res_room, clk, rst_n, res_push, !resq_full, "result pushed into a full result queue")
    `ASSERT_IMPLIES(a_job_avail, clk, rst_n, job_take, !jobq_empty, "job taken from an empty job queue")
    `ASSERT_IMPLIES(a_ok_has_irq, clk, rst_n, !empty && write_ok, irq, "write_ok result without irq")
    `ASSERT_IMPLIES(a_read_quiet, clk, rst_n, !empty && (read_byte != 8'd0 || bytes_left != 8'd0), !irq && !write_ok, "read result carries irq or write_ok")

endmodule

// File: tb/ps2_mouse_device_unit_tb.sv
// self-checking testbench of the ps/2 mouse device: directed items, then random command,
// read and movement sequences, with random idling on both queue interfaces
// depends on psm_pkg and ps2_mouse_device_unit
`timescale 1ns / 1ps

localparam logic [1:0] KIND_UNUSED = 2'd3;
localparam int REPLY_DEPTH = 256;

typedef struct {
    logic [1:0]         kind;
    logic [7:0]         cmd;
    logic signed [10:0] dx;
    logic signed [10:0] dy;
    logic               left;
    logic               middle;
    logic               right;
    logic               present;
} mouse_item_t;

// mirrors the device state and holds the results owed by the block
class mouse_mirror;
    psm_pkg::psm_result_t owed[$];
    int                   failures;
    int                   checked;
    int                   packets;
    int                   dropped;
    int                   empty_reads;

    logic signed [8:0]    x_cnt;
    logic signed [8:0]    y_cnt;
    bit                   x_ovf;
    bit                   y_ovf;
    logic [2:0]           btn;
    bit                   dbl;
    bit                   remote;
    bit                   rep_on;
    psm_pkg::psm_proto_t  proto;
    logic [7:0]           res;
    logic [7:0]           rate;
    logic [7:0]           ring[REPLY_DEPTH];
    int                   head;
    int                   fill;

    function new();
        clear_counts();
        btn = '0;
        restore_defaults();
        ring[0] = psm_pkg::BYTE_BAT_OK;
        ring[1] = psm_pkg::BYTE_DEV_ID;
        head = 0;
        fill = 2;
    endfunction

    function void clear_counts();
        x_cnt = '0;
        y_cnt = '0;
        x_ovf = 1'b0;
        y_ovf = 1'b0;
    endfunction

    function void restore_defaults();
        dbl = 1'b0;
        remote = 1'b0;
        proto = psm_pkg::PS_CMD;
        rep_on = 1'b0;
        res = psm_pkg::RES_DEFAULT;
        rate = psm_pkg::RATE_DEFAULT;
    endfunction

    function void put_byte(logic [7:0] b);
        if (fill >= REPLY_DEPTH) begin
            dropped++;
            return;
        end
        ring[(head + fill) % REPLY_DEPTH] = b;
        fill++;
    endfunction

    function logic [7:0] scaled(logic [7:0] n);
        if (!dbl)
            return n;
        case (n)
            8'd0, 8'd1, 8'd3: return n;
            8'd2:             return 8'd1;
            8'd4:             return 8'd6;
            8'd5:             return 8'd9;
            default:          return {n[6:0], 1'b0};
        endcase
    endfunction

    function void put_packet();
        put_byte({y_ovf, x_ovf, y_cnt[8], x_cnt[8], 1'b1, btn[1], btn[2], btn[0]});
        put_byte(scaled(x_cnt[7:0]));
        put_byte(scaled(y_cnt[7:0]));
        packets++;
    endfunction

    // out of range sums keep the truncated remainder by 255
    function logic signed [8:0] add_motion(logic signed [8:0] cnt, logic signed [10:0] d,
                                           inout bit ovf);
        int shift;
        int sum;
        shift = (res > 8'd3) ? 3 : int'(res);
        sum = int'(cnt) + int'(d) * (1 << shift);
        if (sum > 255 || sum < -256) begin
            ovf = 1'b1;
            sum = sum % 255;
        end
        return 9'(sum);
    endfunction

    function bit run_command(logic [7:0] c);
        case (c)
            psm_pkg::CMD_RESET: begin
                restore_defaults();
                put_byte(psm_pkg::BYTE_ACK);
                put_byte(psm_pkg::BYTE_BAT_OK);
                put_byte(psm_pkg::BYTE_DEV_ID);
            end
            psm_pkg::CMD_RESEND: return 1'b0;
            psm_pkg::CMD_SET_DEFAULTS: begin
                restore_defaults();
                put_byte(psm_pkg::BYTE_ACK);
            end
            psm_pkg::CMD_DISABLE: begin
                rep_on = 1'b0;
                put_byte(psm_pkg::BYTE_ACK);
            end
            psm_pkg::CMD_ENABLE: begin
                rep_on = 1'b1;
                put_byte(psm_pkg::BYTE_ACK);
            end
            psm_pkg::CMD_SET_RATE: begin
                proto = psm_pkg::PS_RATE;
                put_byte(psm_pkg::BYTE_ACK);
            end
            psm_pkg::CMD_GET_ID: begin
                put_byte(psm_pkg::BYTE_ACK);
                put_byte(psm_pkg::BYTE_DEV_ID);
                put_byte(psm_pkg::BYTE_DEV_ID);
            end
            psm_pkg::CMD_SET_REMOTE: begin
                clear_counts();
                remote = 1'b1;
                put_byte(psm_pkg::BYTE_ACK);
            end
            psm_pkg::CMD_SET_WRAP: begin
                clear_counts();
                proto = psm_pkg::PS_WRAP;
                put_byte(psm_pkg::BYTE_ACK);
            end
            psm_pkg::CMD_RESET_WRAP: begin
                clear_counts();
                proto = psm_pkg::PS_CMD;
                put_byte(psm_pkg::BYTE_ACK);
            end
            psm_pkg::CMD_READ_DATA: begin
                put_byte(psm_pkg::BYTE_ACK);
                put_packet();
                clear_counts();
            end
            psm_pkg::CMD_SET_STREAM: begin
                clear_counts();
                remote = 1'b0;
                put_byte(psm_pkg::BYTE_ACK);
            end
            psm_pkg::CMD_STATUS: begin
                put_byte(psm_pkg::BYTE_ACK);
                put_byte({1'b0, remote, rep_on, dbl, 1'b0, btn[0], btn[1], btn[2]});
                put_byte(res);
                put_byte(rate);
            end
            psm_pkg::CMD_SET_RES: begin
                proto = psm_pkg::PS_RES;
                put_byte(psm_pkg::BYTE_ACK);
            end
            psm_pkg::CMD_SCALE_2: begin
                dbl = 1'b1;
                put_byte(psm_pkg::BYTE_ACK);
            end
            psm_pkg::CMD_SCALE_1: begin
                dbl = 1'b0;
                put_byte(psm_pkg::BYTE_ACK);
            end
            default: put_byte(psm_pkg::BYTE_NAK);
        endcase
        return 1'b1;
    endfunction

    function void note_item(mouse_item_t it);
        psm_pkg::psm_result_t r;
        logic [2:0]           nb;
        r = '0;
        nb = {it.right, it.middle, it.left};
        case (it.kind)
            psm_pkg::KIND_WRITE: begin
                r.irq = 1'b1;
                if (proto == psm_pkg::PS_RATE) begin
                    rate = it.cmd;
                    proto = psm_pkg::PS_CMD;
                    put_byte(psm_pkg::BYTE_ACK);
                end
                else if (proto == psm_pkg::PS_RES) begin
                    res = it.cmd;
                    proto = psm_pkg::PS_CMD;
                    put_byte(psm_pkg::BYTE_ACK);
                end
                else if (proto == psm_pkg::PS_WRAP && it.cmd != psm_pkg::CMD_RESET_WRAP
                         && it.cmd != psm_pkg::CMD_RESET)
                    put_byte(it.cmd);
                else
                    r.write_ok = run_command(it.cmd);
            end
            psm_pkg::KIND_READ: begin
                if (fill != 0) begin
                    r.read_byte = ring[head];
                    head = (head + 1) % REPLY_DEPTH;
                    fill--;
                    r.bytes_left = (fill > 255) ? 8'd255 : 8'(fill);
                end
                else
                    empty_reads++;
            end
            psm_pkg::KIND_MOVE: begin
                if (!(it.dx == 0 && it.dy == 0 && (!it.present || nb == btn))) begin
                    if (it.present)
                        btn = nb;
                    x_cnt = add_motion(x_cnt, it.dx, x_ovf);
                    y_cnt = add_motion(y_cnt, it.dy, y_ovf);
                    if (!remote && rep_on) begin
                        put_packet();
                        clear_counts();
                        r.irq = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        owed.push_back(r);
    endfunction

    function void check_result(psm_pkg::psm_result_t got);
        psm_pkg::psm_result_t want;
        if (owed.size() == 0) begin
            $error("result with nothing expected: read_byte %0h irq %0b", got.read_byte,
                   got.irq);
            failures++;
            return;
        end
        want = owed.pop_front();
        checked++;
        if (got.read_byte !== want.read_byte) begin
            $error("read_byte expected %0h, got %0h", want.read_byte, got.read_byte);
            failures++;
        end
        if (got.bytes_left !== want.bytes_left) begin
            $error("bytes_left expected %0d, got %0d", want.bytes_left, got.bytes_left);
            failures++;
        end
        if (got.irq !== want.irq) begin
            $error("irq expected %0b, got %0b", want.irq, got.irq);
            failures++;
        end
        if (got.write_ok !== want.write_ok) begin
            $error("write_ok expected %0b, got %0b", want.write_ok, got.write_ok);
            failures++;
        end
    endfunction
endclass

module ps2_mouse_device_unit_tb;

    localparam int ITEMS_WANTED = 1200;
    localparam int CYCLE_LIMIT  = 600000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               push = 1'b0;
    logic               full;
    logic [1:0]         kind = '0;
    logic [7:0]         cmd_byte = '0;
    logic signed [10:0] move_x = '0;
    logic signed [10:0] move_y = '0;
    logic               btn_left = 1'b0;
    logic               btn_middle = 1'b0;
    logic               btn_right = 1'b0;
    logic               buttons_present = 1'b0;
    logic               empty;
    logic               pop = 1'b0;
    logic [7:0]         read_byte;
    logic [7:0]         bytes_left;
    logic               irq;
    logic               write_ok;

    mouse_mirror mirror;
    int          items_sent = 0;
    int          cycles = 0;
    int          in_stretch = 0;
    bit          in_calm = 1'b0;
    int          out_stretch = 0;
    bit          out_calm = 1'b0;

    logic [7:0] known_cmds[16] = '{psm_pkg::CMD_RESET, psm_pkg::CMD_RESEND,
                                   psm_pkg::CMD_SET_DEFAULTS, psm_pkg::CMD_DISABLE,
                                   psm_pkg::CMD_ENABLE, psm_pkg::CMD_SET_RATE,
                                   psm_pkg::CMD_GET_ID, psm_pkg::CMD_SET_REMOTE,
                                   psm_pkg::CMD_SET_WRAP, psm_pkg::CMD_RESET_WRAP,
                                   psm_pkg::CMD_READ_DATA, psm_pkg::CMD_SET_STREAM,
                                   psm_pkg::CMD_STATUS, psm_pkg::CMD_SET_RES,
                                   psm_pkg::CMD_SCALE_2, psm_pkg::CMD_SCALE_1};

    ps2_mouse_device_unit #(.FIFO_DEPTH(REPLY_DEPTH)) i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .kind            (kind),
        .cmd_byte        (cmd_byte),
        .move_x          (move_x),
        .move_y          (move_y),
        .btn_left        (btn_left),
        .btn_middle      (btn_middle),
        .btn_right       (btn_right),
        .buttons_present (buttons_present),
        .empty           (empty),
        .pop             (pop),
        .read_byte       (read_byte),
        .bytes_left      (bytes_left),
        .irq             (irq),
        .write_ok        (write_ok)
    );

    always #6 clk = ~clk;

    // stretches with random waits and stretches where the side never waits are mixed at random
    function automatic int next_wait(inout int stretch, inout bit calm);
        if (stretch == 0) begin
            stretch = $urandom_range(10, 60);
            calm = ($urandom_range(0, 2) == 0);
        end
        stretch--;
        return calm ? 0 : int'($urandom_range(0, 18));
    endfunction

    function automatic mouse_item_t any_item(logic [1:0] k);
        mouse_item_t it;
        it.kind = k;
        it.cmd = 8'($urandom);
        it.dx = 11'($urandom);
        it.dy = 11'($urandom);
        it.left = 1'($urandom);
        it.middle = 1'($urandom);
        it.right = 1'($urandom);
        it.present = 1'($urandom);
        return it;
    endfunction

    function automatic int pick_delta();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 0;
        if (r < 70)
            return int'($urandom_range(0, 12)) - 6;
        if (r < 90)
            return int'($urandom_range(0, 127)) - 64;
        return int'($urandom_range(0, 2047)) - 1024;
    endfunction

    task automatic send(mouse_item_t it);
        int gap;
        gap = next_wait(in_stretch, in_calm);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        kind <= it.kind;
        cmd_byte <= it.cmd;
        move_x <= it.dx;
        move_y <= it.dy;
        btn_left <= it.left;
        btn_middle <= it.middle;
        btn_right <= it.right;
        buttons_present <= it.present;
        @(posedge clk);
        while (full)
            @(posedge clk);
        mirror.note_item(it);
        items_sent++;
    endtask

    task automatic host_write(logic [7:0] b);
        mouse_item_t it;
        it = any_item(psm_pkg::KIND_WRITE);
        it.cmd = b;
        send(it);
    endtask

    task automatic host_reads(int n);
        repeat (n) send(any_item(psm_pkg::KIND_READ));
    endtask

    task automatic mouse_move(int x, int y, bit present, logic [2:0] btns);
        mouse_item_t it;
        it = any_item(psm_pkg::KIND_MOVE);
        it.dx = 11'(x);
        it.dy = 11'(y);
        it.present = present;
        {it.right, it.middle, it.left} = btns;
        send(it);
    endtask

    task automatic random_moves(int n);
        logic [2:0] btns;
        repeat (n) begin
            // keeping the current buttons makes unchanged events possible
            btns = ($urandom_range(0, 3) == 0) ? mirror.btn : 3'($urandom);
            mouse_move(pick_delta(), pick_delta(), 1'($urandom), btns);
        end
    endtask

    task automatic random_command();
        logic [7:0] c;
        c = ($urandom_range(0, 2) == 0) ? psm_pkg::CMD_ENABLE
                                        : known_cmds[$urandom_range(0, 15)];
        host_write(c);
        if (c == psm_pkg::CMD_SET_RATE)
            host_write(8'($urandom));
        else if (c == psm_pkg::CMD_SET_RES)
            host_write(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3)));
    endtask

    // result side
    initial begin
        int                   gap;
        psm_pkg::psm_result_t got;
        wait (rst_n);
        @(posedge clk);
        forever begin
            gap = next_wait(out_stretch, out_calm);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty)
                @(posedge clk);
            got.read_byte = read_byte;
            got.bytes_left = bytes_left;
            got.irq = irq;
            got.write_ok = write_ok;
            mirror.check_result(got);
        end
    end

    initial begin
        wait (rst_n);
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $error("no finish within %0d cycles, %0d results still owed", CYCLE_LIMIT,
               mirror.owed.size());
        $display("Some tests failed");
        $finish;
    end

    initial begin
        int pick;
        mirror = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // power-on bytes, then a read of the drained queue
        host_reads(3);
        host_write(psm_pkg::CMD_RESEND);
        host_write(8'h00);          // unknown command
        host_write(psm_pkg::CMD_GET_ID);
        host_write(psm_pkg::CMD_STATUS);
        host_write(psm_pkg::CMD_SET_RES);
        host_write(8'd7);           // shift clamps to 3
        host_write(psm_pkg::CMD_SET_RATE);
        host_write(8'd200);
        host_write(psm_pkg::CMD_ENABLE);
        mouse_move(1023, -1024, 1'b1, 3'b111);
        mouse_move(0, 0, 1'b1, 3'b111);
        mouse_move(0, 0, 1'b0, 3'b010);
        host_write(psm_pkg::CMD_SET_RES);
        host_write(8'd0);
        host_write(psm_pkg::CMD_SCALE_2);
        mouse_move(2, 5, 1'b1, 3'b000);
        mouse_move(4, -3, 1'b1, 3'b101);
        send(any_item(KIND_UNUSED));
        host_write(psm_pkg::CMD_SET_WRAP);
        host_write(8'h55);
        host_write(psm_pkg::CMD_RESET);      // leaves wrap mode as a command
        host_write(psm_pkg::CMD_SET_REMOTE);
        host_write(psm_pkg::CMD_READ_DATA);
        host_write(psm_pkg::CMD_SET_STREAM);
        host_write(psm_pkg::CMD_SCALE_1);
        host_write(psm_pkg::CMD_DISABLE);
        host_write(psm_pkg::CMD_SET_DEFAULTS);

        // overfill the reply queue, then drain it past empty
        host_write(psm_pkg::CMD_RESET_WRAP);
        host_write(psm_pkg::CMD_RESET_WRAP);
        repeat (70)
            host_write($urandom_range(0, 1) ? psm_pkg::CMD_STATUS : psm_pkg::CMD_GET_ID);
        host_reads(300);

        while (items_sent < ITEMS_WANTED) begin
            pick = $urandom_range(0, 99);
            if (pick < 25)
                host_reads($urandom_range(1, 8));
            else if (pick < 45)
                random_moves($urandom_range(1, 6));
            else if (pick < 70)
                random_command();
            else if (pick < 77) begin
                host_write(psm_pkg::CMD_SET_WRAP);
                repeat ($urandom_range(1, 5)) begin
                    if ($urandom_range(0, 3) == 0)
                        host_reads(1);
                    else
                        host_write(8'($urandom));
                end
                host_write($urandom_range(0, 1) ? psm_pkg::CMD_RESET_WRAP
                                                : psm_pkg::CMD_RESET);
            end
            else if (pick < 87) begin
                if ($urandom_range(0, 1) == 0)
                    host_write(8'($urandom));
                else
                    send(any_item(KIND_UNUSED));
            end
            else begin
                // remote mode poll
                host_write(psm_pkg::CMD_SET_REMOTE);
                random_moves($urandom_range(1, 4));
                host_write(psm_pkg::CMD_READ_DATA);
                host_reads(4);
                host_write(psm_pkg::CMD_SET_STREAM);
            end
        end
        push <= 1'b0;

        while (mirror.owed.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("%0d items sent, %0d results checked", items_sent, mirror.checked);
        $display("%0d movement packets, %0d reply bytes dropped, %0d reads of an empty queue",
                 mirror.packets, mirror.dropped, mirror.empty_reads);
        if (mirror.failures == 0 && mirror.owed.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
